// File: hdl/fraction_table_soft_pwm_unit_assert.svh
// Assertion macros shared by the soft PWM RTL.
// No dependencies; include by bare file name.
`ifndef FRACTION_TABLE_SOFT_PWM_UNIT_ASSERT_SVH
`define FRACTION_TABLE_SOFT_PWM_UNIT_ASSERT_SVH

// Property must hold on every edge outside reset.
`define FTSPWM_ASSERT_HOLD(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("soft pwm: invariant violated");

// Antecedent at one edge implies the consequent at the next edge.
`define FTSPWM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("soft pwm: sequence violated");

`endif

// File: hdl/ftspwm_pkg.sv
// Package for the soft PWM unit: types, fraction tables and defaults.
// No dependencies.
package ftspwm_pkg;

   localparam int CHANNELS_DEFAULT    = 8;
   localparam int LEVEL_SHIFT_DEFAULT = 3;
   localparam int PIN_BITS            = 8;
   localparam int CHAN_W              = 3;
   localparam int BRIGHT_W            = 8;
   localparam int LEVEL_W             = 5;
   localparam int ACC_W               = 6;

   localparam logic [LEVEL_W-1:0] LEVEL_OFF = 5'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 5'd31;

   typedef enum logic {
      CMD_TICK = 1'b0,
      CMD_SET  = 1'b1
   } cmd_type;

   // Per-channel control from the top level.
   typedef struct packed {
      logic                tick;
      logic                set;
      logic [LEVEL_W-1:0]  level;
   } chan_ctrl_type;

   // Reduced fraction level/32: numerator and denominator; the top level is 1/1 (always on).
   localparam logic [LEVEL_W-1:0] FRAC_NUM [32] = '{
      5'h00, 5'h01, 5'h01, 5'h03, 5'h01, 5'h05, 5'h03, 5'h07,
      5'h01, 5'h09, 5'h05, 5'h0b, 5'h03, 5'h0d, 5'h07, 5'h0f,
      5'h01, 5'h11, 5'h09, 5'h13, 5'h05, 5'h15, 5'h0b, 5'h17,
      5'h03, 5'h19, 5'h0d, 5'h1b, 5'h07, 5'h1d, 5'h0f, 5'h01
   };

   localparam logic [ACC_W-1:0] FRAC_DEN [32] = '{
      6'h20, 6'h20, 6'h10, 6'h20, 6'h08, 6'h20, 6'h10, 6'h20,
      6'h04, 6'h20, 6'h10, 6'h20, 6'h08, 6'h20, 6'h10, 6'h20,
      6'h02, 6'h20, 6'h10, 6'h20, 6'h08, 6'h20, 6'h10, 6'h20,
      6'h04, 6'h20, 6'h10, 6'h20, 6'h08, 6'h20, 6'h10, 6'h01
   };

endpackage

// File: hdl/ftspwm_chan.sv
// One PWM channel: level, Bresenham accumulator and pin.
// Depends on ftspwm_pkg.
module ftspwm_chan (
   input  logic                      clock,
   input  logic                      reset,
   input  ftspwm_pkg::chan_ctrl_type ctrl,
   output logic                      pin_next
);

   logic [ftspwm_pkg::LEVEL_W-1:0] level_ff, level_in;
   logic [ftspwm_pkg::ACC_W-1:0]   accum_ff, accum_in;
   logic                           pin_ff, pin_in;

   logic [ftspwm_pkg::LEVEL_W-1:0] num;
   logic [ftspwm_pkg::ACC_W-1:0]   den;
   logic [ftspwm_pkg::ACC_W-1:0]   num_ext;

   assign num     = ftspwm_pkg::FRAC_NUM[level_ff];
   assign den     = ftspwm_pkg::FRAC_DEN[level_ff];
   assign num_ext = {1'b0, num};

   always_comb begin
      level_in = level_ff;
      accum_in = accum_ff;
      pin_in   = pin_ff;
      if (ctrl.tick) begin
         // below the numerator: add the denominator and drive high
         if (accum_ff < num_ext) begin
            accum_in = accum_ff + den - num_ext;
            pin_in   = 1'b1;
         end else begin
            accum_in = accum_ff - num_ext;
            pin_in   = 1'b0;
         end
      end else if (ctrl.set) begin
         if (ctrl.level == ftspwm_pkg::LEVEL_OFF) begin
            level_in = ftspwm_pkg::LEVEL_OFF;
            pin_in   = 1'b0;
         end else if (ctrl.level != level_ff) begin
            level_in = ctrl.level;
            accum_in = '0;
            if (ctrl.level == ftspwm_pkg::LEVEL_MAX) begin
               pin_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         accum_ff <= '0;
         pin_ff   <= 1'b0;
      end else begin
         level_ff <= level_in;
         accum_ff <= accum_in;
         pin_ff   <= pin_in;
      end
   end

   assign pin_next = pin_in;

endmodule

// File: hdl/fraction_table_soft_pwm_unit.sv
// Top level of the multi-channel soft PWM unit.
// Depends on ftspwm_pkg, ftspwm_chan and fraction_table_soft_pwm_unit_assert.svh.
//
// Usage:
//   The request channel (req_*) carries one command per transfer: a tick that
//   advances every channel's accumulator, or a set that loads a brightness
//   byte into one channel. Brightness is shifted down by LEVEL_SHIFT and
//   saturated to a five-bit level; level zero forces the pin low, level 31
//   forces it high, and a new nonzero level restarts the accumulator.
//   Every request yields exactly one response transfer (rsp_*) with the pin
//   state of channels 0..7 after that command; channels at or above
//   CHANNELS read as zero, and a set to such a channel changes nothing.
//   A request passes the input register and then the result register
//   before response valid rises. Throughput: one transfer per cycle while
//   the receiver keeps taking responses, since the per-channel add and
//   compare are combinational.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more request; req_ready then drops until the
//   response is taken.
//   Reset clears all levels, accumulators and pins (all lamps off) and empties
//   both registers.
`include "fraction_table_soft_pwm_unit_assert.svh"

module fraction_table_soft_pwm_unit #(
   parameter int CHANNELS    = ftspwm_pkg::CHANNELS_DEFAULT,
   parameter int LEVEL_SHIFT = ftspwm_pkg::LEVEL_SHIFT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_cmd,
   input  logic [ftspwm_pkg::CHAN_W-1:0]     req_channel,
   input  logic [ftspwm_pkg::BRIGHT_W-1:0]   req_brightness,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ftspwm_pkg::PIN_BITS-1:0]   rsp_pin_states
);

   // input register
   logic                              in_valid_ff, in_valid_in;
   ftspwm_pkg::cmd_type               in_cmd_ff;
   logic [ftspwm_pkg::CHAN_W-1:0]     in_chan_ff;
   logic [ftspwm_pkg::BRIGHT_W-1:0]   in_bright_ff;

   // result register
   logic                              out_valid_ff, out_valid_in;
   logic [ftspwm_pkg::PIN_BITS-1:0]   out_pins_ff, out_pins_in;

   logic                              exec;
   logic                              req_xfer;
   logic [ftspwm_pkg::BRIGHT_W-1:0]   shifted;
   logic [ftspwm_pkg::LEVEL_W-1:0]    level;
   logic                              chan_ok;
   logic [CHANNELS-1:0]               pins_next;

   // execute when an item waits and the result register is free or draining
   assign exec      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || exec;
   assign req_xfer  = req_valid && req_ready;

   assign in_valid_in  = req_xfer || (in_valid_ff && !exec);
   assign out_valid_in = exec || (out_valid_ff && !rsp_ready);

   // level = brightness >> shift, saturated to the top level
   assign shifted = in_bright_ff >> LEVEL_SHIFT;
   assign level   = (shifted > {3'b000, ftspwm_pkg::LEVEL_MAX}) ?
                    ftspwm_pkg::LEVEL_MAX : shifted[ftspwm_pkg::LEVEL_W-1:0];
   assign chan_ok = (32'(in_chan_ff) < CHANNELS);

   for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
      ftspwm_pkg::chan_ctrl_type ctrl;

      assign ctrl.tick  = exec && (in_cmd_ff == ftspwm_pkg::CMD_TICK);
      assign ctrl.set   = exec && (in_cmd_ff == ftspwm_pkg::CMD_SET)
                          && (32'(in_chan_ff) == i);
      assign ctrl.level = level;

      ftspwm_chan u_chan (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .pin_next (pins_next[i])
      );
   end

   // Pins settle in the same edge as the result register, so build the
   // result from the next pin values of each channel.
   for (genvar b = 0; b < ftspwm_pkg::PIN_BITS; b++) begin : g_pin
      if (b < CHANNELS) begin : g_used
         assign out_pins_in[b] = pins_next[b];
      end else begin : g_unused
         assign out_pins_in[b] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // capture payload on each request transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_cmd_ff    <= ftspwm_pkg::cmd_type'(req_cmd);
         in_chan_ff   <= req_channel;
         in_bright_ff <= req_brightness;
      end
   end

   // load the result as the item executes; hold it while the receiver stalls
   always_ff @(posedge clock) begin
      if (exec) begin
         out_pins_ff <= out_pins_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_pin_states = out_pins_ff;

   `FTSPWM_ASSERT_HOLD(a_ready_only_stalled, clock, reset,
      req_ready || (in_valid_ff && out_valid_ff && !rsp_ready))
   `FTSPWM_ASSERT_NEXT(a_exec_loads_result, clock, reset,
      exec, out_valid_ff)
   `FTSPWM_ASSERT_NEXT(a_full_level_pin_high, clock, reset,
      exec && in_cmd_ff == ftspwm_pkg::CMD_SET && chan_ok
         && level == ftspwm_pkg::LEVEL_MAX && 32'(in_chan_ff) < ftspwm_pkg::PIN_BITS,
      rsp_pin_states[$past(in_chan_ff)])
   `FTSPWM_ASSERT_NEXT(a_off_level_pin_low, clock, reset,
      exec && in_cmd_ff == ftspwm_pkg::CMD_SET && chan_ok
         && level == ftspwm_pkg::LEVEL_OFF,
      !rsp_pin_states[$past(in_chan_ff)])

endmodule

// File: verif/ftspwm_pin_checker.sv
// Pin-state checker for the soft PWM unit: watches both channels, predicts
// the pin states and compares them in order. Depends on ftspwm_pkg.
module ftspwm_pin_checker #(
   parameter int CHANNELS    = ftspwm_pkg::CHANNELS_DEFAULT,
   parameter int LEVEL_SHIFT = ftspwm_pkg::LEVEL_SHIFT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic                              req_cmd,
   input  logic [ftspwm_pkg::CHAN_W-1:0]     req_channel,
   input  logic [ftspwm_pkg::BRIGHT_W-1:0]   req_brightness,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [ftspwm_pkg::PIN_BITS-1:0]   rsp_pin_states,
   output int                                n_failed,
   output int                                n_waiting
);
   timeunit 1ns;
   timeprecision 1ps;

   import ftspwm_pkg::*;

   logic [LEVEL_W-1:0]  lamp_level [CHANNELS];
   logic [ACC_W-1:0]    lamp_accum [CHANNELS];
   logic                lamp_pin   [CHANNELS];
   logic [PIN_BITS-1:0] expected_pins_q [$];
   int                  fail_total;

   // Reduce level/32; full level means always on.
   function automatic void level_fraction(input logic [LEVEL_W-1:0] lvl,
                                          output int num, output int den);
      num = int'(lvl);
      den = 32;
      if (lvl == LEVEL_MAX) begin
         num = 1;
         den = 1;
      end else begin
         while (num != 0 && num % 2 == 0) begin
            num = num / 2;
            den = den / 2;
         end
      end
   endfunction

   function automatic logic [PIN_BITS-1:0] packed_pins();
      logic [PIN_BITS-1:0] bits;
      bits = '0;
      for (int i = 0; i < CHANNELS && i < PIN_BITS; i++)
         bits[i] = lamp_pin[i];
      return bits;
   endfunction

   task automatic advance_lamps();
      int num;
      int den;
      int acc;
      for (int i = 0; i < CHANNELS; i++) begin
         level_fraction(lamp_level[i], num, den);
         acc = int'(lamp_accum[i]);
         if (acc < num) begin
            acc = acc + den;
            lamp_pin[i] = 1'b1;
         end else begin
            lamp_pin[i] = 1'b0;
         end
         acc = acc - num;
         lamp_accum[i] = acc[ACC_W-1:0];
      end
   endtask

   task automatic load_brightness(input int ch, input logic [BRIGHT_W-1:0] raw);
      int lvl;
      lvl = int'(raw) >> LEVEL_SHIFT;
      if (lvl > int'(LEVEL_MAX))
         lvl = int'(LEVEL_MAX);
      if (lvl == int'(LEVEL_OFF)) begin
         lamp_level[ch] = LEVEL_OFF;
         lamp_pin[ch]   = 1'b0;
      end else if (int'(lamp_level[ch]) != lvl) begin
         lamp_level[ch] = lvl[LEVEL_W-1:0];
         lamp_accum[ch] = '0;
         if (lvl == int'(LEVEL_MAX))
            lamp_pin[ch] = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      logic [PIN_BITS-1:0] want;
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            lamp_level[i] = LEVEL_OFF;
            lamp_accum[i] = '0;
            lamp_pin[i]   = 1'b0;
         end
         expected_pins_q.delete();
         fail_total = 0;
      end else begin
         // Compare the response transfer first: it belongs to an older request.
         if (rsp_valid && rsp_ready) begin
            if (expected_pins_q.size() == 0) begin
               $display("%0t: unexpected response, expected none, got pins %02h",
                        $time, rsp_pin_states);
               fail_total++;
            end else begin
               want = expected_pins_q.pop_front();
               if (rsp_pin_states !== want) begin
                  $display("%0t: pin_states mismatch, expected %02h, got %02h",
                           $time, want, rsp_pin_states);
                  fail_total++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (cmd_type'(req_cmd) == CMD_TICK)
               advance_lamps();
            else if (int'(req_channel) < CHANNELS)
               load_brightness(int'(req_channel), req_brightness);
            expected_pins_q.push_back(packed_pins());
         end
      end
      n_failed  <= fail_total;
      n_waiting <= expected_pins_q.size();
   end

endmodule

// File: verif/tb_fraction_table_soft_pwm_unit.sv
// Testbench top for the soft PWM unit: clock, reset, request and response
// stimulus, verdict. Depends on ftspwm_pkg, ftspwm_pin_checker and the RTL.
module tb_fraction_table_soft_pwm_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import ftspwm_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_cmd;
   logic [CHAN_W-1:0]     req_channel;
   logic [BRIGHT_W-1:0]   req_brightness;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [PIN_BITS-1:0]   rsp_pin_states;
   int                    n_failed;
   int                    n_waiting;

   // Last brightness sent per channel, so that repeats of a held level occur.
   logic [BRIGHT_W-1:0]   last_bright [CHANNELS_DEFAULT];

   fraction_table_soft_pwm_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_channel    (req_channel),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pin_states (rsp_pin_states)
   );

   ftspwm_pin_checker u_pin_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_channel    (req_channel),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pin_states (rsp_pin_states),
      .n_failed       (n_failed),
      .n_waiting      (n_waiting)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Offer one command and hold it until the transfer. Valid stays high on
   // return; the next call or a pause decides what happens to it.
   task automatic send_command(input cmd_type c, input logic [CHAN_W-1:0] ch,
                               input logic [BRIGHT_W-1:0] b);
      req_valid      <= 1'b1;
      req_cmd        <= c;
      req_channel    <= ch;
      req_brightness <= b;
      if (c == CMD_SET)
         last_bright[ch] = b;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid for a random stretch: mostly none, sometimes short, rarely long.
   task automatic sender_pause(input bit burst);
      int r;
      int gap;
      r   = $urandom_range(0, 99);
      gap = 0;
      if (!burst) begin
         if (r >= 55 && r < 95)
            gap = $urandom_range(1, 3);
         else if (r >= 95)
            gap = $urandom_range(8, 30);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Random set: favour the off and full ends and repeats of the held level.
   task automatic send_random_set();
      logic [CHAN_W-1:0]   ch;
      logic [BRIGHT_W-1:0] b;
      ch = CHAN_W'($urandom_range(0, CHANNELS_DEFAULT - 1));
      case ($urandom_range(0, 9))
         0: begin
            b = BRIGHT_W'($urandom_range(0, 7));
         end
         1: begin
            b = BRIGHT_W'($urandom_range(248, 255));
         end
         2, 3: begin
            b = last_bright[ch];
         end
         default: begin
            b = BRIGHT_W'($urandom_range(0, 255));
         end
      endcase
      send_command(CMD_SET, ch, b);
   endtask

   // Request side: reset, directed commands, random commands, verdict.
   initial begin
      req_valid      <= 1'b0;
      req_cmd        <= CMD_TICK;
      req_channel    <= '0;
      req_brightness <= '0;
      reset          <= 1'b1;
      for (int i = 0; i < CHANNELS_DEFAULT; i++)
         last_bright[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: all lamps off, then one level per channel, full and off
      // levels, a repeat of the held level, a new level on a running channel.
      send_command(CMD_TICK, 3'd0, 8'h00);      sender_pause(1'b0);
      send_command(CMD_SET,  3'd0, 8'hFF);      sender_pause(1'b0);
      send_command(CMD_SET,  3'd1, 8'h08);      sender_pause(1'b0);
      send_command(CMD_SET,  3'd2, 8'h80);      sender_pause(1'b0);
      send_command(CMD_SET,  3'd3, 8'h7F);      sender_pause(1'b0);
      send_command(CMD_SET,  3'd4, 8'h55);      sender_pause(1'b0);
      send_command(CMD_SET,  3'd5, 8'hAA);      sender_pause(1'b0);
      send_command(CMD_SET,  3'd6, 8'h07);      sender_pause(1'b0);
      send_command(CMD_SET,  3'd7, 8'hF8);      sender_pause(1'b0);
      repeat (4) begin
         send_command(CMD_TICK, 3'd7, 8'hFF);   sender_pause(1'b0);
      end
      send_command(CMD_SET,  3'd2, 8'h87);      sender_pause(1'b0);
      send_command(CMD_SET,  3'd7, 8'h00);      sender_pause(1'b0);
      send_command(CMD_TICK, 3'd0, 8'h00);      sender_pause(1'b0);
      send_command(CMD_SET,  3'd1, 8'h10);      sender_pause(1'b0);
      send_command(CMD_TICK, 3'd5, 8'h5A);      sender_pause(1'b0);
      send_command(CMD_SET,  3'd0, 8'h01);      sender_pause(1'b0);
      send_command(CMD_SET,  3'd6, 8'hFF);      sender_pause(1'b0);
      repeat (2) begin
         send_command(CMD_TICK, 3'd0, 8'h00);   sender_pause(1'b0);
      end

      // Random: mostly ticks so the accumulators run through whole periods,
      // with sets mixed in; some stretches run back to back.
      for (int n = 0; n < 830; n++) begin
         if ($urandom_range(0, 99) < 70)
            send_command(CMD_TICK, CHAN_W'($urandom_range(0, 7)),
                         BRIGHT_W'($urandom_range(0, 255)));
         else
            send_random_set();
         sender_pause(n % 200 < 40);
      end
      req_valid <= 1'b0;

      // Drain: wait for the last expected response, then let the pipe settle.
      do @(posedge clock); while (n_waiting != 0);
      repeat (8) @(posedge clock);
      if (n_failed == 0 && n_waiting == 0)
         $display("tb_fraction_table_soft_pwm_unit: done, clean");
      else
         $display("tb_fraction_table_soft_pwm_unit: done, errors");
      $finish;
   end

   // Response side: random stalls, plus one long hold-off so that the block
   // fills up and drops req_ready while the sender keeps offering.
   initial begin
      int r;
      int spell;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      for (int k = 0; k >= 0; k++) begin
         if (k == 30) begin
            rsp_ready <= 1'b0;
            repeat (120) @(posedge clock);
         end
         spell = $urandom_range(1, 20);
         rsp_ready <= 1'b1;
         repeat (spell) @(posedge clock);
         r = $urandom_range(0, 99);
         if (r < 50)
            spell = 0;
         else if (r < 90)
            spell = $urandom_range(1, 3);
         else
            spell = $urandom_range(8, 30);
         if (spell > 0) begin
            rsp_ready <= 1'b0;
            repeat (spell) @(posedge clock);
         end
      end
   end

   // Hold a hard limit well beyond the slowest correct run.
   initial begin
      #3_000_000;
      $display("tb_fraction_table_soft_pwm_unit: done, errors");
      $finish;
   end

endmodule
